/* rtl/assert_macros.svh */
// Assertion helpers used by the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MME_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MME_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/mme_pkg.sv */
`timescale 1ns / 1ps
package mme_pkg;

  localparam int MAX_DIM_DEF = 16;
  localparam int FIELD_LIMIT = 16;
  localparam int IDX_W       = 4;
  localparam int DIM_W       = 5;
  localparam int DATA_W      = 32;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;
  localparam int QUEUE_DEPTH = 2;
  // Each rounded product needs 2*DATA_W-16 bits; the sum of up to 16 grows by 4.
  localparam int ACC_W = 2 * DATA_W - 16 + $clog2(FIELD_LIMIT);

  localparam logic [DIM_W-1:0] RESET_DIM = DIM_W'(16);

  localparam logic [1:0] ACT_LOAD_A = 2'd0;
  localparam logic [1:0] ACT_LOAD_B = 2'd1;
  localparam logic [1:0] ACT_CALC   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SAT   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [1:0] REG_A_ROWS = 2'd0;
  localparam logic [1:0] REG_INNER  = 2'd1;
  localparam logic [1:0] REG_B_COLS = 2'd2;

  typedef struct packed {
    logic [1:0]              action;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic signed [DATA_W-1:0] product;
    logic [1:0]               status;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_LOAD_A,
    KIND_LOAD_B,
    KIND_CALC,
    KIND_ERR
  } kind_t;

  typedef struct packed {
    kind_t                    kind;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] value;
    logic [DIM_W-1:0]         nk;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_slot_t;

endpackage

/* rtl/matrix_multiply_element.sv */
// A compute item runs through the issue, wait and finish states; its terms pass the read,
// product, rounding and accumulator registers. An out-of-range compute or an inner size
// of zero answers from idle. The single MAC sequencer reads one A and one B entry per
// cycle and runs one item at a time; load items retire at one per cycle while it is idle.
// Reset (rst_n low, synchronous) restores the three size registers to 16 and empties the
// item queue; the A and B stores keep no reset state. The receiver cannot stall results.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module matrix_multiply_element #(
  parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  mme_pkg::in_item_t              in_data,
  output logic                           out_valid,
  output mme_pkg::out_item_t             out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mme_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mme_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mme_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import mme_pkg::*;

  // The front end owns the size registers and sorts each item: loads outside the
  // configured sizes and unknown actions are dropped here, and a compute request
  // outside the result size is turned into an error item. Everything kept goes into
  // a short queue so that loads and computes reach the stores in arrival order.
  logic      q_push, q_pop, q_full;
  job_t      q_push_job;
  job_slot_t q_head;

  assign pready = 1'b1;
  assign busy   = q_full;

  mme_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (q_push),
    .push_job (q_push_job),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
  );

  mme_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_push_job),
    .pop      (q_pop),
    .full     (q_full),
    .head     (q_head)
  );

  // The back end holds the A and B stores. It writes each load on pop and runs
  // a compute as a pipelined multiply-accumulate over the inner dimension: read,
  // multiply, round, accumulate, and finally saturate into the result register.
  mme_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // An out-of-range request always reports a zero product.
  `MME_ASSERT_IMP(a_range_zero, clk, rst_n, out_valid && out_data.status == ST_RANGE, out_data.product == '0)
  // A saturated result sits at one of the two 32-bit limits.
  `MME_ASSERT_IMP(a_sat_clamp, clk, rst_n, out_valid && out_data.status == ST_SAT, out_data.product == 32'sh7FFFFFFF || out_data.product == 32'sh80000000)
  // The queue only fills up because an item was just taken in.
  `MME_ASSERT_IMP(a_busy_cause, clk, rst_n, $rose(busy), $past(start))
  // A full queue stays full until the back end takes an item.
  `MME_ASSERT_NXT(a_busy_hold, clk, rst_n, busy && !q_pop, busy)

endmodule

/* rtl/mme_front.sv */
`timescale 1ns / 1ps
module mme_front #(
  parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  mme_pkg::in_item_t               in_data,
  input  logic                            q_full,
  output logic                            push,
  output mme_pkg::job_t                   push_job,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mme_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [mme_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [mme_pkg::CFG_DATA_W-1:0]  prdata
);
  import mme_pkg::*;

  localparam int LIM = (MAX_DIM < FIELD_LIMIT) ? MAX_DIM : FIELD_LIMIT;
  localparam logic [DIM_W-1:0] LIM_V = DIM_W'(LIM);

  logic [DIM_W-1:0] a_rows_r, inner_r, b_cols_r;
  logic [DIM_W-1:0] nr, nk, nc;
  logic [1:0]       reg_idx;
  logic             cfg_wr;
  logic             keep;

  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r <= RESET_DIM;
      inner_r  <= RESET_DIM;
      b_cols_r <= RESET_DIM;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_A_ROWS: a_rows_r <= pwdata[DIM_W-1:0];
        REG_INNER:  inner_r  <= pwdata[DIM_W-1:0];
        REG_B_COLS: b_cols_r <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_A_ROWS: prdata = CFG_DATA_W'(a_rows_r);
      REG_INNER:  prdata = CFG_DATA_W'(inner_r);
      REG_B_COLS: prdata = CFG_DATA_W'(b_cols_r);
      default:    prdata = '0;
    endcase
  end

  // Sizes are clamped to what the stores and the index fields can hold.
  assign nr = (a_rows_r < LIM_V) ? a_rows_r : LIM_V;
  assign nk = (inner_r  < LIM_V) ? inner_r  : LIM_V;
  assign nc = (b_cols_r < LIM_V) ? b_cols_r : LIM_V;

  always_comb begin
    push_job.kind  = KIND_ERR;
    push_job.row   = in_data.row;
    push_job.col   = in_data.col;
    push_job.value = in_data.value;
    push_job.nk    = nk;
    keep           = 1'b0;
    unique case (in_data.action)
      ACT_LOAD_A: begin
        push_job.kind = KIND_LOAD_A;
        keep = ({1'b0, in_data.row} < nr) && ({1'b0, in_data.col} < nk);
      end
      ACT_LOAD_B: begin
        push_job.kind = KIND_LOAD_B;
        keep = ({1'b0, in_data.row} < nk) && ({1'b0, in_data.col} < nc);
      end
      ACT_CALC: begin
        keep = 1'b1;
        if (({1'b0, in_data.row} < nr) && ({1'b0, in_data.col} < nc)) begin
          push_job.kind = KIND_CALC;
        end
      end
      default: keep = 1'b0;
    endcase
  end

  assign push = start && !q_full && keep;

endmodule

/* rtl/mme_queue.sv */
`timescale 1ns / 1ps
module mme_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mme_pkg::job_t      push_job,
  input  logic               pop,
  output logic               full,
  output mme_pkg::job_slot_t head
);
  import mme_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full       = (count_r == FULL_CNT);
  assign head.valid = (count_r != '0);
  assign head.job   = slots[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

/* rtl/mme_back.sv */
`timescale 1ns / 1ps
module mme_back #(
  parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mme_pkg::job_slot_t head,
  output logic               pop,
  output logic               out_valid,
  output mme_pkg::out_item_t out_data
);
  import mme_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] DIM_MUL = ADDR_W'(MAX_DIM);
  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(-64'sd2147483648);
  localparam int TERM_W = 2 * DATA_W - 16;

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_FIN} state_t;

  state_t state_r;

  logic signed [DATA_W-1:0] a_mem [DEPTH];
  logic signed [DATA_W-1:0] b_mem [DEPTH];

  logic [IDX_W-1:0]           row_r, col_r, k_r;
  logic [DIM_W-1:0]           nk_r;
  logic                       v1_r, l1_r, v2_r, l2_r, v3_r, l3_r;
  logic signed [DATA_W-1:0]   a_q_r, b_q_r;
  logic signed [2*DATA_W-1:0] p_r;
  logic signed [2*DATA_W-1:0] rnd;
  logic signed [TERM_W-1:0]   t_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic                       out_valid_r;
  out_item_t                  out_data_r;

  logic              issue, last_k, wr_a, wr_b;
  logic [ADDR_W-1:0] waddr, a_raddr, b_raddr;

  assign pop     = (state_r == S_IDLE) && head.valid;
  assign issue   = (state_r == S_ISSUE);
  assign last_k  = ({1'b0, k_r} == nk_r - DIM_W'(1));
  assign wr_a    = pop && (head.job.kind == KIND_LOAD_A);
  assign wr_b    = pop && (head.job.kind == KIND_LOAD_B);
  assign waddr   = ADDR_W'(head.job.row) * DIM_MUL + ADDR_W'(head.job.col);
  assign a_raddr = ADDR_W'(row_r) * DIM_MUL + ADDR_W'(k_r);
  assign b_raddr = ADDR_W'(k_r) * DIM_MUL + ADDR_W'(col_r);

  always_ff @(posedge clk) begin
    if (wr_a) begin
      a_mem[waddr] <= head.job.value;
    end
    if (wr_b) begin
      b_mem[waddr] <= head.job.value;
    end
    a_q_r <= a_mem[a_raddr];
    b_q_r <= b_mem[b_raddr];
  end

  // Multiply, then round to Q16.16 by adding one half and flooring.
  assign rnd = p_r + (2*DATA_W)'(32768);

  always_ff @(posedge clk) begin
    p_r <= a_q_r * b_q_r;
    t_r <= rnd[2*DATA_W-1:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      v1_r        <= 1'b0;
      l1_r        <= 1'b0;
      v2_r        <= 1'b0;
      l2_r        <= 1'b0;
      v3_r        <= 1'b0;
      l3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= issue;
      l1_r        <= issue && last_k;
      v2_r        <= v1_r;
      l2_r        <= l1_r;
      v3_r        <= v2_r;
      l3_r        <= l2_r;
      out_valid_r <= 1'b0;
      if (v3_r) begin
        acc_r <= acc_r + ACC_W'(t_r);
      end
      unique case (state_r)
        S_IDLE: begin
          if (head.valid) begin
            unique case (head.job.kind)
              KIND_ERR: begin
                out_valid_r        <= 1'b1;
                out_data_r.out_row <= head.job.row;
                out_data_r.out_col <= head.job.col;
                out_data_r.product <= '0;
                out_data_r.status  <= ST_RANGE;
              end
              KIND_CALC: begin
                if (head.job.nk == '0) begin
                  out_valid_r        <= 1'b1;
                  out_data_r.out_row <= head.job.row;
                  out_data_r.out_col <= head.job.col;
                  out_data_r.product <= '0;
                  out_data_r.status  <= ST_OK;
                end else begin
                  row_r   <= head.job.row;
                  col_r   <= head.job.col;
                  nk_r    <= head.job.nk;
                  k_r     <= '0;
                  acc_r   <= '0;
                  state_r <= S_ISSUE;
                end
              end
              default: ;
            endcase
          end
        end
        S_ISSUE: begin
          k_r <= k_r + IDX_W'(1);
          if (last_k) begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (v3_r && l3_r) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          out_valid_r        <= 1'b1;
          out_data_r.out_row <= row_r;
          out_data_r.out_col <= col_r;
          if (acc_r > ACC_MAX) begin
            out_data_r.product <= ACC_MAX[DATA_W-1:0];
            out_data_r.status  <= ST_SAT;
          end else if (acc_r < ACC_MIN) begin
            out_data_r.product <= ACC_MIN[DATA_W-1:0];
            out_data_r.status  <= ST_SAT;
          end else begin
            out_data_r.product <= acc_r[DATA_W-1:0];
            out_data_r.status  <= ST_OK;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
